// ----- hw/rtl/fcull_pkg.sv -----
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared types and constants of the frustum cull test.
// ----------------------------------------------------------------------------
package fcull_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int PLANE_WIDTH = 64;
	localparam int COEF_WIDTH  = 16;
	localparam int FRAC_BITS   = 14;
	localparam int CFG_IDX_W   = 3;

	typedef logic [PLANE_WIDTH-1:0] plane_t;
	typedef plane_t [PLANE_COUNT-1:0] plane_array_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLANE_LEFT   = 3'd0,
		REG_PLANE_RIGHT  = 3'd1,
		REG_PLANE_BOTTOM = 3'd2,
		REG_PLANE_TOP    = 3'd3,
		REG_PLANE_NEAR   = 3'd4,
		REG_PLANE_FAR    = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		VERDICT_OUTSIDE = 2'd0,
		VERDICT_INSIDE  = 2'd1,
		VERDICT_CROSS   = 2'd2
	} verdict_t;

	typedef enum logic {
		OP_BOX    = 1'b0,
		OP_SPHERE = 1'b1
	} opcode_t;

	// stage enables shared by the plane lanes
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} pipe_ctl_t;

endpackage

// ----- hw/rtl/fcull_if.sv -----
// ----------------------------------------------------------------------------
// fcull_if
// Valid/ready channels of the frustum cull test: bounds in, verdict out.
// ----------------------------------------------------------------------------
interface fcull_bounds_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic signed [COORD_WIDTH-1:0] box_min_x;
	logic signed [COORD_WIDTH-1:0] box_min_y;
	logic signed [COORD_WIDTH-1:0] box_min_z;
	logic signed [COORD_WIDTH-1:0] box_max_x;
	logic signed [COORD_WIDTH-1:0] box_max_y;
	logic signed [COORD_WIDTH-1:0] box_max_z;
	logic signed [COORD_WIDTH-1:0] center_x;
	logic signed [COORD_WIDTH-1:0] center_y;
	logic signed [COORD_WIDTH-1:0] center_z;
	logic        [COORD_WIDTH-1:0] sphere_radius;

	modport source (
		output valid, opcode, box_min_x, box_min_y, box_min_z,
		       box_max_x, box_max_y, box_max_z,
		       center_x, center_y, center_z, sphere_radius,
		input  ready
	);
	modport sink (
		input  valid, opcode, box_min_x, box_min_y, box_min_z,
		       box_max_x, box_max_y, box_max_z,
		       center_x, center_y, center_z, sphere_radius,
		output ready
	);
endinterface

interface fcull_verdict_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface

// ----- hw/rtl/frustum_cull_test.sv -----
// ----------------------------------------------------------------------------
// frustum_cull_test
// Classifies a box or a sphere against six configured frustum planes.
//
// One transaction is accepted every clock cycle unless the pipeline stalls,
// and each verdict passes in order through the registers of vertex select,
// one bank of 16 x COORD_WIDTH multipliers per plane, the distance adders
// and the output register that merges the six plane flags. All six planes
// are evaluated in parallel lanes. Each stage stalls only when occupied
// and blocked, so bubbles collapse while the output waits. Plane registers
// must be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module frustum_cull_test #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	fcull_bounds_if.sink                        bounds,
	fcull_verdict_if.source                     result,
	input  logic                                cfg_we,
	input  logic [fcull_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fcull_pkg::PLANE_WIDTH-1:0]   cfg_wdata
);

	localparam int NP = fcull_pkg::PLANE_COUNT;

	fcull_pkg::plane_array_t planes;
	fcull_pkg::pipe_ctl_t    ctl;

	logic            valid_s1, valid_s2, valid_s3, out_valid_q;
	logic            box_s1, box_s2, box_s3;
	logic            en_out;
	logic [NP-1:0]   far_neg_s3, near_neg_s3;
	logic [1:0]      verdict_q;

	fcull_plane_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.planes    (planes)
	);

	assign en_out    = !out_valid_q || result.ready;
	assign ctl.en_s3 = !valid_s3 || en_out;
	assign ctl.en_s2 = !valid_s2 || ctl.en_s3;
	assign ctl.en_s1 = !valid_s1 || ctl.en_s2;

	assign bounds.ready = ctl.en_s1;

	for (genvar i = 0; i < NP; i++) begin : g_lane
		fcull_plane_lane #(
			.COORD_WIDTH (COORD_WIDTH)
		) u_lane (
			.clk           (clk),
			.ctl           (ctl),
			.plane         (planes[i]),
			.opcode        (bounds.opcode),
			.box_min_x     (bounds.box_min_x),
			.box_min_y     (bounds.box_min_y),
			.box_min_z     (bounds.box_min_z),
			.box_max_x     (bounds.box_max_x),
			.box_max_y     (bounds.box_max_y),
			.box_max_z     (bounds.box_max_z),
			.center_x      (bounds.center_x),
			.center_y      (bounds.center_y),
			.center_z      (bounds.center_z),
			.sphere_radius (bounds.sphere_radius),
			.far_neg_s3    (far_neg_s3[i]),
			.near_neg_s3   (near_neg_s3[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.en_s1) valid_s1 <= bounds.valid;
			if (ctl.en_s2) valid_s2 <= valid_s1;
			if (ctl.en_s3) valid_s3 <= valid_s2;
			if (en_out)    out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s1) box_s1 <= (bounds.opcode == fcull_pkg::OP_BOX);
		if (ctl.en_s2) box_s2 <= box_s1;
		if (ctl.en_s3) box_s3 <= box_s2;
		if (en_out) begin
			if (|far_neg_s3)
				verdict_q <= fcull_pkg::VERDICT_OUTSIDE;
			else if (box_s3 && (|near_neg_s3))
				verdict_q <= fcull_pkg::VERDICT_CROSS;
			else
				verdict_q <= fcull_pkg::VERDICT_INSIDE;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.verdict = verdict_q;

	a_empty_output_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> bounds.ready)
		else $error("input blocked while output register is empty");

	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !ctl.en_s3) |=> valid_s3)
		else $error("stage 3 transaction dropped during stall");

	a_verdict_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.verdict == fcull_pkg::VERDICT_OUTSIDE ||
		                  result.verdict == fcull_pkg::VERDICT_INSIDE ||
		                  result.verdict == fcull_pkg::VERDICT_CROSS))
		else $error("illegal verdict code");

endmodule

// ----- hw/rtl/fcull_plane_regs.sv -----
// ----------------------------------------------------------------------------
// fcull_plane_regs
// Six 64-bit plane registers written through the configuration port.
// ----------------------------------------------------------------------------
module fcull_plane_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fcull_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fcull_pkg::PLANE_WIDTH-1:0]   cfg_wdata,
	output fcull_pkg::plane_array_t             planes
);

	fcull_pkg::plane_array_t planes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fcull_pkg::REG_PLANE_LEFT:   planes_q[0] <= cfg_wdata;
				fcull_pkg::REG_PLANE_RIGHT:  planes_q[1] <= cfg_wdata;
				fcull_pkg::REG_PLANE_BOTTOM: planes_q[2] <= cfg_wdata;
				fcull_pkg::REG_PLANE_TOP:    planes_q[3] <= cfg_wdata;
				fcull_pkg::REG_PLANE_NEAR:   planes_q[4] <= cfg_wdata;
				fcull_pkg::REG_PLANE_FAR:    planes_q[5] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign planes = planes_q;

endmodule

// ----- hw/rtl/fcull_plane_lane.sv -----
// ----------------------------------------------------------------------------
// fcull_plane_lane
// One plane: vertex select, products, signed distance sums and sign flags.
// ----------------------------------------------------------------------------
module fcull_plane_lane #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                clk,
	input  fcull_pkg::pipe_ctl_t                ctl,
	input  fcull_pkg::plane_t                   plane,
	input  logic                                opcode,
	input  logic signed [COORD_WIDTH-1:0]       box_min_x,
	input  logic signed [COORD_WIDTH-1:0]       box_min_y,
	input  logic signed [COORD_WIDTH-1:0]       box_min_z,
	input  logic signed [COORD_WIDTH-1:0]       box_max_x,
	input  logic signed [COORD_WIDTH-1:0]       box_max_y,
	input  logic signed [COORD_WIDTH-1:0]       box_max_z,
	input  logic signed [COORD_WIDTH-1:0]       center_x,
	input  logic signed [COORD_WIDTH-1:0]       center_y,
	input  logic signed [COORD_WIDTH-1:0]       center_z,
	input  logic        [COORD_WIDTH-1:0]       sphere_radius,
	output logic                                far_neg_s3,
	output logic                                near_neg_s3
);

	localparam int CW   = COORD_WIDTH;
	localparam int KW   = fcull_pkg::COEF_WIDTH;
	localparam int PW   = KW + CW;
	localparam int OW   = ((CW + 1 > KW) ? CW + 1 : KW) + 1;
	localparam int OSW  = OW + fcull_pkg::FRAC_BITS;
	localparam int SW   = ((PW > OSW) ? PW : OSW) + 2;

	logic signed [KW-1:0] coef_a, coef_b, coef_c, coef_d;

	assign coef_a = signed'(plane[63:48]);
	assign coef_b = signed'(plane[47:32]);
	assign coef_c = signed'(plane[31:16]);
	assign coef_d = signed'(plane[15:0]);

	// stage 1: far and near vertex, radius term
	logic signed [CW-1:0] fx_s1, fy_s1, fz_s1, qx_s1, qy_s1, qz_s1;
	logic        [CW-1:0] rad_s1;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			if (opcode == fcull_pkg::OP_SPHERE) begin
				fx_s1  <= center_x;
				fy_s1  <= center_y;
				fz_s1  <= center_z;
				rad_s1 <= sphere_radius;
			end else begin
				fx_s1  <= coef_a[KW-1] ? box_min_x : box_max_x;
				fy_s1  <= coef_b[KW-1] ? box_min_y : box_max_y;
				fz_s1  <= coef_c[KW-1] ? box_min_z : box_max_z;
				rad_s1 <= '0;
			end
			qx_s1 <= coef_a[KW-1] ? box_max_x : box_min_x;
			qy_s1 <= coef_b[KW-1] ? box_max_y : box_min_y;
			qz_s1 <= coef_c[KW-1] ? box_max_z : box_min_z;
		end
	end

	// stage 2: products and offsets
	logic signed [PW-1:0] pfx_s2, pfy_s2, pfz_s2, pqx_s2, pqy_s2, pqz_s2;
	logic signed [OW-1:0] off_far_s2, off_near_s2;
	logic signed [OW-1:0] d_ext, rad_ext;

	assign d_ext   = OW'(coef_d);
	assign rad_ext = signed'(OW'(rad_s1));

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			pfx_s2      <= PW'(coef_a) * PW'(fx_s1);
			pfy_s2      <= PW'(coef_b) * PW'(fy_s1);
			pfz_s2      <= PW'(coef_c) * PW'(fz_s1);
			pqx_s2      <= PW'(coef_a) * PW'(qx_s1);
			pqy_s2      <= PW'(coef_b) * PW'(qy_s1);
			pqz_s2      <= PW'(coef_c) * PW'(qz_s1);
			off_far_s2  <= d_ext + rad_ext;
			off_near_s2 <= d_ext;
		end
	end

	// stage 3: distance sums, keep the sign only
	logic signed [SW-1:0] far_sum, near_sum;

	assign far_sum  = SW'(pfx_s2) + SW'(pfy_s2) + SW'(pfz_s2)
	                + (SW'(off_far_s2) <<< fcull_pkg::FRAC_BITS);
	assign near_sum = SW'(pqx_s2) + SW'(pqy_s2) + SW'(pqz_s2)
	                + (SW'(off_near_s2) <<< fcull_pkg::FRAC_BITS);

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			far_neg_s3  <= far_sum[SW-1];
			near_neg_s3 <= near_sum[SW-1];
		end
	end

endmodule

// ----- tb/tb_frustum_cull_test.sv -----
// ----------------------------------------------------------------------------
// tb_frustum_cull_test
// Self-checking bench for the frustum cull test. Plane sets are loaded
// through the configuration port while the block is idle, then boxes and
// spheres are streamed in with random gaps on both channels. A scoreboard
// mirrors the planes, predicts each verdict when bounds are accepted and
// compares every returned verdict in order.
// ----------------------------------------------------------------------------
module tb_frustum_cull_test;

	localparam int CW           = 16;
	localparam int KW           = fcull_pkg::COEF_WIDTH;
	localparam int IDX_W        = fcull_pkg::CFG_IDX_W;
	localparam int MAX_CYCLES   = 200000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int PHASE_ITEMS  = 110;
	localparam int CALM_TAIL    = 150;
	localparam int DRAIN_CYCLES = 8;
	localparam int UNIT         = 1 << fcull_pkg::FRAC_BITS;

	localparam logic [KW-1:0] COEF_MOST_NEG  = {1'b1, {(KW-1){1'b0}}};
	localparam logic [KW-1:0] COEF_MOST_POS  = ~COEF_MOST_NEG;
	localparam logic [KW-1:0] COEF_MINUS_ONE = '1;

	typedef enum {
		PLANES_AXIS,
		PLANES_TILTED,
		PLANES_EXTREME,
		PLANES_NOISE
	} plane_style_t;

	typedef struct packed {
		fcull_pkg::opcode_t op;
		logic [2:0][CW-1:0] bmin;
		logic [2:0][CW-1:0] bmax;
		logic [2:0][CW-1:0] ctr;
		logic [CW-1:0]      radius;
	} bounds_t;

	class cull_scoreboard;
		fcull_pkg::plane_t   planes[fcull_pkg::PLANE_COUNT];
		fcull_pkg::verdict_t pending_verdicts[$];
		int                  errors;
		int                  box_count;
		int                  sphere_count;
		int                  verdict_tally[4];

		function new();
			foreach (planes[i]) planes[i] = '0;
			foreach (verdict_tally[i]) verdict_tally[i] = 0;
			errors = 0;
			box_count = 0;
			sphere_count = 0;
		endfunction

		function void set_plane(int idx, fcull_pkg::plane_t value);
			if (idx < fcull_pkg::PLANE_COUNT) planes[idx] = value;
		endfunction

		function longint distance(fcull_pkg::plane_t p, longint x, longint y, longint z);
			return longint'($signed(p[63:48])) * x + longint'($signed(p[47:32])) * y
				+ longint'($signed(p[31:16])) * z
				+ (longint'($signed(p[15:0])) <<< fcull_pkg::FRAC_BITS);
		endfunction

		function fcull_pkg::verdict_t classify(bounds_t b);
			longint lo[3];
			longint hi[3];
			longint far_pt[3];
			longint near_pt[3];
			longint rad;
			bit     crossing;
			crossing = 1'b0;
			if (b.op == fcull_pkg::OP_BOX) begin
				for (int k = 0; k < 3; k++) begin
					lo[k] = longint'($signed(b.bmin[k]));
					hi[k] = longint'($signed(b.bmax[k]));
				end
				for (int i = 0; i < fcull_pkg::PLANE_COUNT; i++) begin
					for (int k = 0; k < 3; k++) begin
						if ($signed(planes[i][63-16*k -: 16]) < 0) begin
							far_pt[k] = lo[k];
							near_pt[k] = hi[k];
						end else begin
							far_pt[k] = hi[k];
							near_pt[k] = lo[k];
						end
					end
					if (distance(planes[i], far_pt[0], far_pt[1], far_pt[2]) < 0)
						return fcull_pkg::VERDICT_OUTSIDE;
					if (distance(planes[i], near_pt[0], near_pt[1], near_pt[2]) < 0)
						crossing = 1'b1;
				end
				return crossing ? fcull_pkg::VERDICT_CROSS : fcull_pkg::VERDICT_INSIDE;
			end
			rad = longint'(b.radius) <<< fcull_pkg::FRAC_BITS;
			for (int i = 0; i < fcull_pkg::PLANE_COUNT; i++) begin
				if (distance(planes[i], longint'($signed(b.ctr[0])), longint'($signed(b.ctr[1])),
						longint'($signed(b.ctr[2]))) + rad < 0)
					return fcull_pkg::VERDICT_OUTSIDE;
			end
			return fcull_pkg::VERDICT_INSIDE;
		endfunction

		function void note_bounds(bounds_t b);
			fcull_pkg::verdict_t want;
			want = classify(b);
			pending_verdicts.insert(pending_verdicts.size(), want);
			verdict_tally[want]++;
			if (b.op == fcull_pkg::OP_BOX) box_count++;
			else sphere_count++;
		endfunction

		function void check_verdict(logic [1:0] got);
			fcull_pkg::verdict_t want;
			if (pending_verdicts.size() == 0) begin
				errors++;
				$display("%0t: verdict %0d arrived with no transaction outstanding", $time, got);
				return;
			end
			want = pending_verdicts.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: verdict mismatch: expected %0d, actual %0d", $time, want, got);
			end
		endfunction

		function int outstanding();
			return pending_verdicts.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	fcull_pkg::plane_t cfg_wdata;
	bit                idle_on;
	int                stall_left;
	int                cycles;
	int                settings_loaded;
	cull_scoreboard    sb = new();

	fcull_bounds_if #(.COORD_WIDTH(CW)) bounds_ch();
	fcull_verdict_if                    verdict_ch();

	frustum_cull_test #(.COORD_WIDTH(CW)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bounds    (bounds_ch),
		.result    (verdict_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			verdict_ch.ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			verdict_ch.ready <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			verdict_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : watch
		bounds_t got_b;
		if (arst_n) begin
			if (bounds_ch.valid && bounds_ch.ready) begin
				got_b.op = fcull_pkg::opcode_t'(bounds_ch.opcode);
				got_b.bmin[0] = bounds_ch.box_min_x;
				got_b.bmin[1] = bounds_ch.box_min_y;
				got_b.bmin[2] = bounds_ch.box_min_z;
				got_b.bmax[0] = bounds_ch.box_max_x;
				got_b.bmax[1] = bounds_ch.box_max_y;
				got_b.bmax[2] = bounds_ch.box_max_z;
				got_b.ctr[0] = bounds_ch.center_x;
				got_b.ctr[1] = bounds_ch.center_y;
				got_b.ctr[2] = bounds_ch.center_z;
				got_b.radius = bounds_ch.sphere_radius;
				sb.note_bounds(got_b);
			end
			if (verdict_ch.valid && verdict_ch.ready) sb.check_verdict(verdict_ch.verdict);
		end
	end

	function automatic logic [CW-1:0] clip_coord(int v);
		if (v > (1 << (CW-1)) - 1) v = (1 << (CW-1)) - 1;
		if (v < -(1 << (CW-1))) v = -(1 << (CW-1));
		return CW'(v);
	endfunction

	function automatic bounds_t random_bounds();
		bounds_t b;
		b.op = fcull_pkg::opcode_t'($urandom_range(0, 1));
		for (int k = 0; k < 3; k++) begin
			b.bmin[k] = CW'($urandom);
			b.bmax[k] = CW'($urandom);
			b.ctr[k] = CW'($urandom);
		end
		b.radius = CW'($urandom);
		return b;
	endfunction

	function automatic bounds_t box_item(int mnx, int mny, int mnz, int mxx, int mxy, int mxz);
		bounds_t b;
		b = random_bounds();
		b.op = fcull_pkg::OP_BOX;
		b.bmin[0] = clip_coord(mnx);
		b.bmin[1] = clip_coord(mny);
		b.bmin[2] = clip_coord(mnz);
		b.bmax[0] = clip_coord(mxx);
		b.bmax[1] = clip_coord(mxy);
		b.bmax[2] = clip_coord(mxz);
		return b;
	endfunction

	function automatic bounds_t sphere_item(int cx, int cy, int cz, int r);
		bounds_t b;
		b = random_bounds();
		b.op = fcull_pkg::OP_SPHERE;
		b.ctr[0] = clip_coord(cx);
		b.ctr[1] = clip_coord(cy);
		b.ctr[2] = clip_coord(cz);
		b.radius = CW'(r);
		return b;
	endfunction

	function automatic bounds_t rand_item(int span);
		bounds_t b;
		int      c[3];
		int      h[3];
		int      pick;
		b = random_bounds();
		pick = $urandom_range(0, 99);
		if (pick < 15) return b;
		for (int k = 0; k < 3; k++) begin
			c[k] = int'($urandom_range(0, 4 * span)) - 2 * span;
			h[k] = $urandom_range(0, span);
		end
		if (pick < 60) begin
			b.op = fcull_pkg::OP_BOX;
			for (int k = 0; k < 3; k++) begin
				if (pick < 54) begin
					b.bmin[k] = clip_coord(c[k] - h[k]);
					b.bmax[k] = clip_coord(c[k] + h[k]);
				end else begin
					b.bmin[k] = clip_coord(c[k] + h[k]);
					b.bmax[k] = clip_coord(c[k] - h[k]);
				end
			end
		end else begin
			b.op = fcull_pkg::OP_SPHERE;
			for (int k = 0; k < 3; k++) b.ctr[k] = clip_coord(c[k]);
			b.radius = (pick < 95) ? CW'($urandom_range(0, span)) : CW'($urandom);
		end
		return b;
	endfunction

	function automatic fcull_pkg::plane_t pack_plane(int a, int b, int c, int d);
		return {16'(a), 16'(b), 16'(c), 16'(d)};
	endfunction

	function automatic fcull_pkg::plane_array_t frustum_planes(int span, int tilt, int jitter);
		fcull_pkg::plane_array_t p;
		int                      coef[3];
		for (int i = 0; i < fcull_pkg::PLANE_COUNT; i++) begin
			for (int k = 0; k < 3; k++)
				coef[k] = (tilt == 0) ? 0 : int'($urandom_range(0, 2 * tilt)) - tilt;
			coef[i / 2] = (i % 2 == 0) ? UNIT : -UNIT;
			p[i] = pack_plane(coef[0], coef[1], coef[2], span + int'($urandom_range(0, jitter)));
		end
		return p;
	endfunction

	function automatic fcull_pkg::plane_array_t wild_planes(bit fully_random);
		fcull_pkg::plane_array_t p;
		logic [KW-1:0]           f;
		for (int i = 0; i < fcull_pkg::PLANE_COUNT; i++) begin
			for (int j = 0; j < 4; j++) begin
				case ($urandom_range(0, 4))
					0: f = COEF_MOST_NEG;
					1: f = COEF_MOST_POS;
					2: f = '0;
					3: f = COEF_MINUS_ONE;
					default: f = KW'($urandom);
				endcase
				p[i][63-16*j -: 16] = fully_random ? KW'($urandom) : f;
			end
		end
		return p;
	endfunction

	task automatic send_bounds(input bounds_t b);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			bounds_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		bounds_ch.valid <= 1'b1;
		bounds_ch.opcode <= b.op;
		bounds_ch.box_min_x <= b.bmin[0];
		bounds_ch.box_min_y <= b.bmin[1];
		bounds_ch.box_min_z <= b.bmin[2];
		bounds_ch.box_max_x <= b.bmax[0];
		bounds_ch.box_max_y <= b.bmax[1];
		bounds_ch.box_max_z <= b.bmax[2];
		bounds_ch.center_x <= b.ctr[0];
		bounds_ch.center_y <= b.ctr[1];
		bounds_ch.center_z <= b.ctr[2];
		bounds_ch.sphere_radius <= b.radius;
		@(posedge clk);
		while (!bounds_ch.ready) @(posedge clk);
	endtask

	task automatic settle();
		bounds_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_planes(input fcull_pkg::plane_array_t p);
		fcull_pkg::plane_t value;
		for (int i = 0; i < 2 ** IDX_W; i++) begin
			value = (i < fcull_pkg::PLANE_COUNT) ? p[i] : {$urandom, $urandom};
			cfg_we <= 1'b1;
			cfg_index <= (i < fcull_pkg::PLANE_COUNT) ? fcull_pkg::cfg_reg_t'(i) : IDX_W'(i);
			cfg_wdata <= value;
			sb.set_plane(i, value);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	initial begin
		fcull_pkg::plane_array_t p;
		plane_style_t            style;
		int                      span;
		int                      sent;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_on = 1'b1;
		stall_left = 0;
		cycles = 0;
		sent = 0;
		settings_loaded = 0;
		verdict_ch.ready = 1'b0;
		bounds_ch.valid = 1'b0;
		bounds_ch.opcode = fcull_pkg::OP_BOX;
		bounds_ch.box_min_x = '0;
		bounds_ch.box_min_y = '0;
		bounds_ch.box_min_z = '0;
		bounds_ch.box_max_x = '0;
		bounds_ch.box_max_y = '0;
		bounds_ch.box_max_z = '0;
		bounds_ch.center_x = '0;
		bounds_ch.center_y = '0;
		bounds_ch.center_z = '0;
		bounds_ch.sphere_radius = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero planes after reset: nothing is culled
		send_bounds(box_item(-32768, -32768, -32768, 32767, 32767, 32767));
		send_bounds(sphere_item(32767, -32768, 0, 0));
		settle();

		// axis-aligned cube of half-width 1000
		load_planes(frustum_planes(1000, 0, 0));
		send_bounds(box_item(-10, -10, -10, 10, 10, 10));
		send_bounds(box_item(-1500, -10, -10, -900, 10, 10));
		send_bounds(box_item(1001, 0, 0, 2000, 5, 5));
		send_bounds(box_item(-1000, -1000, -1000, 1000, 1000, 1000));
		send_bounds(box_item(-32768, -32768, -32768, 32767, 32767, 32767));
		send_bounds(box_item(10, 10, 10, -10, -10, -10));
		send_bounds(box_item(5000, 5000, 5000, -5000, -5000, -5000));
		send_bounds(box_item(-32768, -32768, -32768, -32768, -32768, -32768));
		send_bounds(box_item(500, 500, 500, 500, 500, 500));
		send_bounds(sphere_item(0, 0, 0, 0));
		send_bounds(sphere_item(1500, 0, 0, 500));
		send_bounds(sphere_item(1501, 0, 0, 500));
		send_bounds(sphere_item(32767, 32767, 32767, 65535));
		settle();

		load_planes({fcull_pkg::PLANE_COUNT{pack_plane(-32768, -32768, -32768, -32768)}});
		send_bounds(box_item(-32768, -32768, -32768, 32767, 32767, 32767));
		send_bounds(sphere_item(32767, 32767, 32767, 65535));
		settle();

		load_planes({fcull_pkg::PLANE_COUNT{pack_plane(32767, 32767, 32767, 32767)}});
		send_bounds(box_item(-32768, -32768, -32768, 32767, 32767, 32767));
		send_bounds(sphere_item(-32768, -32768, -32768, 0));
		settle();

		// zero normal with negative offset culls every box but not a sphere of nonzero radius
		p = '0;
		p[fcull_pkg::REG_PLANE_FAR] = pack_plane(0, 0, 0, -1);
		load_planes(p);
		send_bounds(box_item(-32768, -32768, -32768, 32767, 32767, 32767));
		send_bounds(sphere_item(0, 0, 0, 65535));
		settle();

		for (int ph = 0; ph < RANDOM_ITEMS / PHASE_ITEMS; ph++) begin
			style = plane_style_t'(ph % 4);
			if (ph == RANDOM_ITEMS / PHASE_ITEMS - 1) style = PLANES_AXIS;
			span = $urandom_range(200, 6000);
			case (style)
				PLANES_AXIS: p = frustum_planes(span, 0, span / 4);
				PLANES_TILTED: p = frustum_planes(span, $urandom_range(500, 8000), span / 4);
				PLANES_EXTREME: begin
					span = 16000;
					p = wild_planes(1'b0);
				end
				default: begin
					span = 16000;
					p = wild_planes(1'b1);
				end
			endcase
			load_planes(p);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 32 == 0)
					idle_on = (sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
				send_bounds(rand_item(span));
				sent++;
			end
			settle();
		end

		$display("covered %0d box and %0d sphere tests over %0d plane settings",
			sb.box_count, sb.sphere_count, settings_loaded);
		$display("verdicts seen: %0d outside, %0d inside, %0d crossing",
			sb.verdict_tally[fcull_pkg::VERDICT_OUTSIDE],
			sb.verdict_tally[fcull_pkg::VERDICT_INSIDE],
			sb.verdict_tally[fcull_pkg::VERDICT_CROSS]);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
